[hdl/frame_header_field_parser_assert.svh]
// assertion macros for the frame header field parser
`ifndef FRAME_HEADER_FIELD_PARSER_ASSERT_SVH
`define FRAME_HEADER_FIELD_PARSER_ASSERT_SVH

// same-cycle implication
`define FHP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define FHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hdl/fhp_pkg.sv]
// ----------------------------------------------------------------------------
// fhp_pkg
// types, codes and helpers shared by the frame header field parser
// ----------------------------------------------------------------------------
`default_nettype none

package fhp_pkg;

    localparam int MAX_REF_SLOTS_DEF = 16;
    localparam int QDEPTH            = 4;

    // register indexes
    localparam logic [2:0] RI_SEQ_FLAGS  = 3'd0;
    localparam logic [2:0] RI_NUM_SLOTS  = 3'd1;
    localparam logic [2:0] RI_OH_WIDTH   = 3'd2;
    localparam logic [2:0] RI_LT_WIDTH   = 3'd3;
    localparam logic [2:0] RI_W_BITS     = 3'd4;
    localparam logic [2:0] RI_H_BITS     = 3'd5;
    localparam logic [2:0] RI_MAX_W      = 3'd6;
    localparam logic [2:0] RI_MAX_H      = 3'd7;

    // sequence flag bits
    localparam int SF_GRAIN    = 0;
    localparam int SF_SINGLE   = 1;
    localparam int SF_MONO     = 2;
    localparam int SF_SHORTREF = 3;
    localparam int SF_EXPLMAP  = 4;
    localparam int SF_BRU      = 5;
    localparam int SF_REFMVS   = 6;
    localparam int SF_SB256    = 7;
    localparam int SF_SB128    = 8;
    localparam int SF_ONELAYER = 9;

    // unit kinds
    localparam logic [2:0] K_TILE   = 3'd0;
    localparam logic [2:0] K_CLEAN  = 3'd1;
    localparam logic [2:0] K_OPEN   = 3'd2;
    localparam logic [2:0] K_SWITCH = 3'd3;
    localparam logic [2:0] K_RA     = 3'd4;
    localparam logic [2:0] K_BRIDGE = 3'd5;
    localparam logic [2:0] K_TIP    = 3'd6;
    localparam logic [2:0] K_SHOW   = 3'd7;

    // frame types
    localparam logic [1:0] FT_KEY    = 2'd0;
    localparam logic [1:0] FT_INTER  = 2'd1;
    localparam logic [1:0] FT_INTRA  = 2'd2;
    localparam logic [1:0] FT_SWITCH = 2'd3;

    localparam logic [31:0] PRI_NONE   = 32'd7;
    localparam logic [31:0] PRI_CHOOSE = 32'd8;
    localparam logic [3:0]  OH_MAX     = 4'd8;

    // element codes
    localparam logic [5:0] EC_MFH_ID     = 6'd0;
    localparam logic [5:0] EC_SEQ_ID     = 6'd1;
    localparam logic [5:0] EC_BRIDGE_IDX = 6'd2;
    localparam logic [5:0] EC_SHOW_IDX   = 6'd3;
    localparam logic [5:0] EC_DERIVE_OH  = 6'd4;
    localparam logic [5:0] EC_SEF_OH     = 6'd5;
    localparam logic [5:0] EC_APPLY_FG   = 6'd6;
    localparam logic [5:0] EC_FG_MODEL   = 6'd7;
    localparam logic [5:0] EC_FG_SEED    = 6'd8;
    localparam logic [5:0] EC_RESTR_SW   = 6'd9;
    localparam logic [5:0] EC_IS_INTER   = 6'd10;
    localparam logic [5:0] EC_FTYPE      = 6'd11;
    localparam logic [5:0] EC_LTID_P1    = 6'd12;
    localparam logic [5:0] EC_LTID       = 6'd13;
    localparam logic [5:0] EC_NUM_KEY    = 6'd14;
    localparam logic [5:0] EC_REF_LTID   = 6'd15;
    localparam logic [5:0] EC_IMM_OUT    = 6'd16;
    localparam logic [5:0] EC_IMPL_OUT   = 6'd17;
    localparam logic [5:0] EC_SIZE_OVR   = 6'd18;
    localparam logic [5:0] EC_ORDER_HINT = 6'd19;
    localparam logic [5:0] EC_SIG_PRI    = 6'd20;
    localparam logic [5:0] EC_DIS_CDF    = 6'd21;
    localparam logic [5:0] EC_PRI_REF    = 6'd22;
    localparam logic [5:0] EC_BR_OVW     = 6'd23;
    localparam logic [5:0] EC_HAS_REF    = 6'd24;
    localparam logic [5:0] EC_FTR        = 6'd25;
    localparam logic [5:0] EC_REFRESH    = 6'd26;
    localparam logic [5:0] EC_EXPL_MAP   = 6'd27;
    localparam logic [5:0] EC_NUM_REFS   = 6'd28;
    localparam logic [5:0] EC_REF_IDX    = 6'd29;
    localparam logic [5:0] EC_FOUND_REF  = 6'd30;
    localparam logic [5:0] EC_WIDTH      = 6'd31;
    localparam logic [5:0] EC_HEIGHT     = 6'd32;
    localparam logic [5:0] EC_USE_BRU    = 6'd33;
    localparam logic [5:0] EC_BRU_REF    = 6'd34;
    localparam logic [5:0] EC_BRU_INACT  = 6'd35;
    localparam logic [5:0] EC_USE_MVS    = 6'd36;
    localparam logic [5:0] EC_TMVP_STEP  = 6'd37;
    localparam logic [5:0] EC_IS_INTRA   = 6'd38;
    localparam logic [5:0] EC_SHOW_EXIST = 6'd39;
    localparam logic [5:0] EC_IS_OUTPUT  = 6'd40;
    localparam logic [5:0] EC_TIP_MODE   = 6'd41;

    typedef enum logic [5:0] {
        S_IDLE, S_MFH, S_SEQ, S_BIDX, S_MODE, S_MODE_IMM, S_MODE_IMPL, S_SHOW,
        S_DOH, S_SOH, S_GRAIN, S_FGM, S_SEED, S_SEFEND, S_FTYPE, S_FTYPE_OUT,
        S_LTID, S_LTID_M1, S_NKEY, S_KEYREF, S_IMM, S_IMPL, S_OVR, S_OVR_PRI,
        S_OH, S_PRI, S_CDF, S_PRIVAL, S_BROVW, S_REFRESH, S_HASREF, S_REF_NONE,
        S_FTR, S_FTR_MASK, S_RFULL, S_SIZE, S_W, S_H, S_DEF_W, S_DEF_H, S_EXPL,
        S_NREFS, S_REFIDX, S_FSZ, S_FOUND, S_BRU, S_BRUREF, S_BRUINACT, S_MVS,
        S_TMVP, S_FIN_INTRA, S_FIN_SEF, S_FIN_OUT, S_FIN_TIP
    } t_step;

    typedef struct packed {
        logic [9:0]  seq_flags;
        logic [4:0]  num_slots;
        logic [3:0]  oh_width;
        logic [3:0]  lt_width;
        logic [4:0]  w_bits;
        logic [4:0]  h_bits;
        logic [16:0] max_w;
        logic [16:0] max_h;
    } t_cfg;

    typedef struct packed {
        logic        last;
        logic [31:0] value;
        logic [5:0]  code;
    } t_rec;

    function automatic t_rec f_rec(logic [5:0] c, logic [31:0] v, logic l);
        t_rec r;
        r.code  = c;
        r.value = v;
        r.last  = l;
        return r;
    endfunction

    function automatic logic [5:0] f_clog2(logic [4:0] n);
        logic [5:0] k;
        if (n <= 5'd1)       k = 6'd0;
        else if (n <= 5'd2)  k = 6'd1;
        else if (n <= 5'd4)  k = 6'd2;
        else if (n <= 5'd8)  k = 6'd3;
        else if (n <= 5'd16) k = 6'd4;
        else                 k = 6'd5;
        return k;
    endfunction

    function automatic logic [5:0] f_fbits(logic [4:0] b);
        logic [5:0] k;
        if (b == 5'd0)       k = 6'd1;
        else if (b > 5'd16)  k = 6'd16;
        else                 k = {1'b0, b};
        return k;
    endfunction

endpackage

`default_nettype wire

[hdl/frame_header_field_parser.sv]
// ----------------------------------------------------------------------------
// frame_header_field_parser
// bit-serial parser for the leading part of a video frame header
// ----------------------------------------------------------------------------
// A start word (tuser set) latches the unit kind; every later word carries one
// header bit. While a field is being collected a bit word is taken each cycle.
// When a field completes, the header sequencer runs its parse steps (at most
// one record each) and holds s_tready low until it needs the next bit;
// records pass through a four-entry queue, so the sequencer only stalls when
// that queue is full. The last record of a header has m_tlast set.
`default_nettype none

module frame_header_field_parser #(
    parameter int MAX_REF_SLOTS = fhp_pkg::MAX_REF_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // unit_kind[2:0], bit_req[3], zero pad
    input  wire logic [0:0]  s_tuser,  // start_req[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // element_code[5:0], element_value[37:6], pad
    output logic             m_tlast   // header_done
);

    fhp_pkg::t_cfg r_cfg;
    fhp_pkg::t_rec w_rec, w_out;
    logic          w_push, w_full;
    logic          cfg_wr;
    logic [2:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.seq_flags <= 10'd0;
            r_cfg.num_slots <= 5'd8;
            r_cfg.oh_width  <= 4'd7;
            r_cfg.lt_width  <= 4'd0;
            r_cfg.w_bits    <= 5'd16;
            r_cfg.h_bits    <= 5'd16;
            r_cfg.max_w     <= 17'd65536;
            r_cfg.max_h     <= 17'd65536;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                fhp_pkg::RI_SEQ_FLAGS: r_cfg.seq_flags <= pwdata[9:0];
                fhp_pkg::RI_NUM_SLOTS: r_cfg.num_slots <= pwdata[4:0];
                fhp_pkg::RI_OH_WIDTH:  r_cfg.oh_width  <= pwdata[3:0];
                fhp_pkg::RI_LT_WIDTH:  r_cfg.lt_width  <= pwdata[3:0];
                fhp_pkg::RI_W_BITS:    r_cfg.w_bits    <= pwdata[4:0];
                fhp_pkg::RI_H_BITS:    r_cfg.h_bits    <= pwdata[4:0];
                fhp_pkg::RI_MAX_W:     r_cfg.max_w     <= pwdata[16:0];
                fhp_pkg::RI_MAX_H:     r_cfg.max_h     <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            fhp_pkg::RI_SEQ_FLAGS: prdata = {22'd0, r_cfg.seq_flags};
            fhp_pkg::RI_NUM_SLOTS: prdata = {27'd0, r_cfg.num_slots};
            fhp_pkg::RI_OH_WIDTH:  prdata = {28'd0, r_cfg.oh_width};
            fhp_pkg::RI_LT_WIDTH:  prdata = {28'd0, r_cfg.lt_width};
            fhp_pkg::RI_W_BITS:    prdata = {27'd0, r_cfg.w_bits};
            fhp_pkg::RI_H_BITS:    prdata = {27'd0, r_cfg.h_bits};
            fhp_pkg::RI_MAX_W:     prdata = {15'd0, r_cfg.max_w};
            fhp_pkg::RI_MAX_H:     prdata = {15'd0, r_cfg.max_h};
            default:               prdata = 32'd0;
        endcase
    end

    fhp_front #(
        .MAX_REF_SLOTS(MAX_REF_SLOTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_start (s_tuser[0]),
        .i_kind  (s_tdata[2:0]),
        .i_bit   (s_tdata[3]),
        .i_cfg   (r_cfg),
        .o_push  (w_push),
        .o_rec   (w_rec),
        .i_full  (w_full)
    );

    fhp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .o_full  (w_full),
        .o_valid (m_tvalid),
        .o_rec   (w_out),
        .i_ready (m_tready)
    );

    assign m_tdata = {2'b00, w_out.value, w_out.code};
    assign m_tlast = w_out.last;

`include "frame_header_field_parser_assert.svh"

    `FHP_ASSERT_SAME(a_no_push_full, w_push, !w_full)
    `FHP_ASSERT_NEXT(a_start_busy, s_tvalid && s_tready && s_tuser[0], !s_tready)
    `FHP_ASSERT_NEXT(a_last_idle, w_push && w_rec.last, s_tready)

endmodule

`default_nettype wire

[hdl/fhp_front.sv]
// ----------------------------------------------------------------------------
// fhp_front
// accepts start and bit words, shifts fields in and steps the header sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module fhp_front #(
    parameter int MAX_REF_SLOTS = fhp_pkg::MAX_REF_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_start,
    input  wire logic [2:0]    i_kind,
    input  wire logic          i_bit,
    input  wire fhp_pkg::t_cfg i_cfg,
    output logic               o_push,
    output fhp_pkg::t_rec      o_rec,
    input  wire logic          i_full
);

    typedef struct packed {
        logic       intra;
        logic       imm;
        logic       impl;
        logic       ovr;
        logic       ovw;
        logic       expl;
        logic       bruin;
        logic       mvs;
        logic       sigpri;
        logic       sef;
        logic [1:0] ft;
    } t_hflags;

    fhp_pkg::t_step r_step, n_step;
    logic [5:0]     r_cnt, n_cnt;
    logic [31:0]    r_acc, n_acc;
    logic [2:0]     r_kind, n_kind;
    t_hflags        r_fl, n_fl;
    logic [2:0]     r_refc, n_refc;
    logic [3:0]     r_loop, n_loop;
    logic [3:0]     r_bslot, n_bslot;
    logic [5:0]     r_uvz, n_uvz;
    logic           r_uvph, n_uvph;
    logic           r_ready, n_ready;
    logic [31:0]    r_hold, n_hold;

    logic        busy, run, bridge, need, ok;
    logic [5:0]  want;
    logic [31:0] gv, v;
    logic [4:0]  slots;
    logic [5:0]  slot_bits;
    logic [5:0]  ohw;
    logic [16:0] all_mask;
    logic        uv_done, uv_ld;
    logic [31:0] uv_val;
    logic [5:0]  uv_cnt, uv_nz;
    logic        uv_nph;
    logic [1:0]  ft_new;

    assign busy    = (r_step != fhp_pkg::S_IDLE) && (r_cnt == 6'd0);
    assign o_ready = !busy;
    assign run     = busy && !i_full;
    assign bridge  = (r_kind == fhp_pkg::K_BRIDGE);
    assign gv      = r_ready ? r_acc : 32'd0;
    assign slots   = (i_cfg.num_slots > 5'(MAX_REF_SLOTS)) ? 5'(MAX_REF_SLOTS)
                                                          : i_cfg.num_slots;
    assign slot_bits = fhp_pkg::f_clog2(slots);
    assign ohw       = {2'b00, (i_cfg.oh_width > fhp_pkg::OH_MAX) ? fhp_pkg::OH_MAX
                                                                  : i_cfg.oh_width};
    assign all_mask  = (17'd1 << slots) - 17'd1;

    // variable length code step
    always_comb begin
        uv_done = 1'b0;
        uv_val  = 32'd0;
        uv_ld   = 1'b0;
        uv_cnt  = 6'd1;
        uv_nz   = r_uvz;
        uv_nph  = r_uvph;
        if (!r_uvph) begin
            if (!r_ready) begin
                uv_ld = 1'b1;
            end else if (!r_acc[0]) begin
                uv_ld = 1'b1;
                if (r_uvz < 6'd32) uv_nz = r_uvz + 6'd1;
            end else if (r_uvz >= 6'd32) begin
                uv_done = 1'b1;
                uv_val  = '1;
                uv_nz   = 6'd0;
            end else if (r_uvz == 6'd0) begin
                uv_done = 1'b1;
            end else begin
                uv_nph = 1'b1;
                uv_ld  = 1'b1;
                uv_cnt = r_uvz;
            end
        end else begin
            uv_done = 1'b1;
            uv_val  = r_acc + ((32'd1 << r_uvz[4:0]) - 32'd1);
            uv_nph  = 1'b0;
            uv_nz   = 6'd0;
        end
    end

    always_comb begin
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_acc   = r_acc;
        n_kind  = r_kind;
        n_fl    = r_fl;
        n_refc  = r_refc;
        n_loop  = r_loop;
        n_bslot = r_bslot;
        n_uvz   = r_uvz;
        n_uvph  = r_uvph;
        n_ready = r_ready;
        n_hold  = r_hold;
        o_push  = 1'b0;
        o_rec   = fhp_pkg::f_rec(fhp_pkg::EC_MFH_ID, 32'd0, 1'b0);
        need    = 1'b0;
        want    = 6'd0;
        ok      = 1'b1;
        v       = 32'd0;
        ft_new  = fhp_pkg::FT_KEY;

        if (i_valid && o_ready) begin
            if (i_start) begin
                n_kind  = i_kind;
                n_fl    = '0;
                n_cnt   = 6'd0;
                n_acc   = 32'd0;
                n_refc  = 3'd0;
                n_loop  = 4'd0;
                n_bslot = 4'd0;
                n_uvz   = 6'd0;
                n_uvph  = 1'b0;
                n_ready = 1'b0;
                n_step  = fhp_pkg::S_MFH;
            end else if (r_step != fhp_pkg::S_IDLE && r_cnt != 6'd0) begin
                n_acc = {r_acc[30:0], i_bit};
                n_cnt = r_cnt - 6'd1;
                if (r_cnt == 6'd1) n_ready = 1'b1;
            end
        end else if (run) begin
            unique case (r_step)
                fhp_pkg::S_MFH, fhp_pkg::S_SEQ: begin
                    if (bridge && r_step == fhp_pkg::S_MFH) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_MFH_ID, 32'd0, 1'b0);
                        n_step = fhp_pkg::S_SEQ;
                    end else begin
                        n_acc   = 32'd0;
                        n_ready = 1'b0;
                        n_uvz   = uv_nz;
                        n_uvph  = uv_nph;
                        if (uv_ld) n_cnt = uv_cnt;
                        if (uv_done) begin
                            o_push = 1'b1;
                            if (r_step == fhp_pkg::S_MFH) begin
                                o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_MFH_ID, uv_val, 1'b0);
                                n_step = (uv_val == 32'd0) ? fhp_pkg::S_SEQ
                                                           : fhp_pkg::S_BIDX;
                            end else begin
                                o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_SEQ_ID, uv_val, 1'b0);
                                n_step = fhp_pkg::S_BIDX;
                            end
                        end
                    end
                end
                fhp_pkg::S_BIDX: begin
                    if (bridge) begin
                        need = 1'b1; want = slot_bits; ok = r_ready || want == 6'd0;
                    end
                    if (ok) begin
                        if (bridge) begin
                            n_bslot = gv[3:0];
                            o_push  = 1'b1;
                            o_rec   = fhp_pkg::f_rec(fhp_pkg::EC_BRIDGE_IDX,
                                                     {28'd0, gv[3:0]}, 1'b0);
                        end
                        n_step = fhp_pkg::S_MODE;
                    end
                end
                fhp_pkg::S_MODE: begin
                    if (i_cfg.seq_flags[fhp_pkg::SF_SINGLE]) begin
                        n_fl.ft    = fhp_pkg::FT_KEY;
                        n_fl.intra = 1'b1;
                        n_fl.imm   = 1'b1;
                        n_fl.impl  = 1'b0;
                        o_push     = 1'b1;
                        o_rec      = fhp_pkg::f_rec(fhp_pkg::EC_FTYPE, 32'd0, 1'b0);
                        n_step     = fhp_pkg::S_MODE_IMM;
                    end else if (r_kind == fhp_pkg::K_SHOW) begin
                        n_fl.sef = 1'b1;
                        n_fl.imm = 1'b1;
                        n_step   = fhp_pkg::S_SHOW;
                    end else begin
                        n_step = fhp_pkg::S_FTYPE;
                    end
                end
                fhp_pkg::S_MODE_IMM: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_IMM_OUT, 32'd1, 1'b0);
                    n_step = fhp_pkg::S_MODE_IMPL;
                end
                fhp_pkg::S_MODE_IMPL: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_IMPL_OUT, 32'd0, 1'b0);
                    n_step = fhp_pkg::S_OVR;
                end
                fhp_pkg::S_SHOW: begin
                    need = 1'b1; want = slot_bits; ok = r_ready || want == 6'd0;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_SHOW_IDX, gv, 1'b0);
                        n_step = fhp_pkg::S_DOH;
                    end
                end
                fhp_pkg::S_DOH: begin
                    need = 1'b1; want = 6'd1; ok = r_ready;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_DERIVE_OH, gv, 1'b0);
                        n_step = (gv != 32'd0) ? fhp_pkg::S_GRAIN : fhp_pkg::S_SOH;
                    end
                end
                fhp_pkg::S_SOH: begin
                    need = 1'b1; want = ohw; ok = r_ready || want == 6'd0;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_SEF_OH, gv, 1'b0);
                        n_step = fhp_pkg::S_GRAIN;
                    end
                end
                fhp_pkg::S_GRAIN: begin
                    if (!i_cfg.seq_flags[fhp_pkg::SF_GRAIN] || (!r_fl.imm && !r_fl.impl)) begin
                        v = 32'd0;
                    end else if (i_cfg.seq_flags[fhp_pkg::SF_SINGLE]) begin
                        v = 32'd1;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                    end
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_APPLY_FG, v, 1'b0);
                        n_step = (v != 32'd0) ? fhp_pkg::S_FGM : fhp_pkg::S_SEFEND;
                    end
                end
                fhp_pkg::S_FGM: begin
                    need = 1'b1; want = 6'd3; ok = r_ready;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_FG_MODEL, gv, 1'b0);
                        n_step = fhp_pkg::S_SEED;
                    end
                end
                fhp_pkg::S_SEED: begin
                    need = 1'b1; want = 6'd16; ok = r_ready;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_FG_SEED, gv, 1'b0);
                        n_step = fhp_pkg::S_SEFEND;
                    end
                end
                fhp_pkg::S_SEFEND: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH, 32'd0, 1'b0);
                    n_step = fhp_pkg::S_DEF_W;
                end
                fhp_pkg::S_FTYPE: begin
                    if (bridge || r_kind == fhp_pkg::K_TIP) begin
                        ft_new = fhp_pkg::FT_INTER;
                    end else if (r_kind == fhp_pkg::K_SWITCH || r_kind == fhp_pkg::K_RA) begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        ft_new = fhp_pkg::FT_SWITCH;
                        o_push = ok;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_RESTR_SW, gv, 1'b0);
                    end else if (r_kind == fhp_pkg::K_CLEAN || r_kind == fhp_pkg::K_OPEN) begin
                        ft_new = fhp_pkg::FT_KEY;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        ft_new = gv[0] ? fhp_pkg::FT_INTER : fhp_pkg::FT_INTRA;
                        o_push = ok;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_IS_INTER, gv, 1'b0);
                    end
                    if (ok) begin
                        n_fl.ft    = ft_new;
                        n_fl.intra = (ft_new == fhp_pkg::FT_KEY) ||
                                     (ft_new == fhp_pkg::FT_INTRA);
                        n_step     = fhp_pkg::S_FTYPE_OUT;
                    end
                end
                fhp_pkg::S_FTYPE_OUT: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_FTYPE, {30'd0, r_fl.ft}, 1'b0);
                    n_step = fhp_pkg::S_LTID;
                end
                fhp_pkg::S_LTID: begin
                    if (r_fl.ft == fhp_pkg::FT_KEY && i_cfg.lt_width != 4'd0) begin
                        need = 1'b1; want = {2'b00, i_cfg.lt_width}; ok = r_ready;
                        if (ok) begin
                            n_hold = gv;
                            o_push = 1'b1;
                            o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_LTID_P1, gv, 1'b0);
                            n_step = fhp_pkg::S_LTID_M1;
                        end
                    end else begin
                        n_step = fhp_pkg::S_NKEY;
                    end
                end
                fhp_pkg::S_LTID_M1: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_LTID, r_hold - 32'd1, 1'b0);
                    n_step = fhp_pkg::S_NKEY;
                end
                fhp_pkg::S_NKEY: begin
                    if ((r_kind == fhp_pkg::K_RA || r_kind == fhp_pkg::K_OPEN) &&
                        i_cfg.lt_width != 4'd0) begin
                        need = 1'b1; want = 6'd3; ok = r_ready;
                        if (ok) begin
                            n_loop = {1'b0, gv[2:0]};
                            o_push = 1'b1;
                            o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_NUM_KEY, gv, 1'b0);
                            n_step = (gv[2:0] != 3'd0) ? fhp_pkg::S_KEYREF : fhp_pkg::S_IMM;
                        end
                    end else begin
                        n_step = fhp_pkg::S_IMM;
                    end
                end
                fhp_pkg::S_KEYREF: begin
                    need = 1'b1; want = {2'b00, i_cfg.lt_width}; ok = r_ready || want == 6'd0;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REF_LTID, gv, 1'b0);
                        n_loop = r_loop - 4'd1;
                        if (r_loop == 4'd1) n_step = fhp_pkg::S_IMM;
                    end
                end
                fhp_pkg::S_IMM: begin
                    if (bridge || r_kind == fhp_pkg::K_OPEN) begin
                        v = 32'd0;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                    end
                    if (ok) begin
                        n_fl.imm = v[0];
                        o_push   = 1'b1;
                        o_rec    = fhp_pkg::f_rec(fhp_pkg::EC_IMM_OUT, v, 1'b0);
                        n_step   = fhp_pkg::S_IMPL;
                    end
                end
                fhp_pkg::S_IMPL: begin
                    if (bridge || r_fl.imm || i_cfg.seq_flags[fhp_pkg::SF_MONO]) begin
                        v = 32'd0;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                    end
                    if (ok) begin
                        n_fl.impl = v[0];
                        o_push    = 1'b1;
                        o_rec     = fhp_pkg::f_rec(fhp_pkg::EC_IMPL_OUT, v, 1'b0);
                        n_step    = fhp_pkg::S_OVR;
                    end
                end
                fhp_pkg::S_OVR: begin
                    if (bridge) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_ORDER_HINT, 32'd0, 1'b0);
                        n_step = fhp_pkg::S_OVR_PRI;
                    end else begin
                        if (r_fl.ft == fhp_pkg::FT_SWITCH) begin
                            v = 32'd1;
                        end else if (i_cfg.seq_flags[fhp_pkg::SF_SINGLE]) begin
                            v = 32'd0;
                        end else begin
                            need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                        end
                        if (ok) begin
                            n_fl.ovr = v[0];
                            o_push   = 1'b1;
                            o_rec    = fhp_pkg::f_rec(fhp_pkg::EC_SIZE_OVR, v, 1'b0);
                            n_step   = fhp_pkg::S_OH;
                        end
                    end
                end
                fhp_pkg::S_OVR_PRI: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_PRI_REF, fhp_pkg::PRI_NONE, 1'b0);
                    n_step = fhp_pkg::S_BROVW;
                end
                fhp_pkg::S_OH: begin
                    need = 1'b1; want = ohw; ok = r_ready || want == 6'd0;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_ORDER_HINT, gv, 1'b0);
                        n_step = fhp_pkg::S_PRI;
                    end
                end
                fhp_pkg::S_PRI: begin
                    if (r_fl.intra || r_fl.ft == fhp_pkg::FT_SWITCH) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_PRI_REF, fhp_pkg::PRI_NONE, 1'b0);
                        n_step = fhp_pkg::S_BROVW;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        if (ok) begin
                            n_fl.sigpri = gv[0];
                            o_push      = 1'b1;
                            o_rec       = fhp_pkg::f_rec(fhp_pkg::EC_SIG_PRI, gv, 1'b0);
                            n_step      = fhp_pkg::S_CDF;
                        end
                    end
                end
                fhp_pkg::S_CDF: begin
                    if (r_kind != fhp_pkg::K_TIP) begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        o_push = ok;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_DIS_CDF, gv, 1'b0);
                    end
                    if (ok) n_step = fhp_pkg::S_PRIVAL;
                end
                fhp_pkg::S_PRIVAL: begin
                    if (r_fl.sigpri) begin
                        need = 1'b1; want = 6'd3; ok = r_ready; v = gv;
                    end else begin
                        v = fhp_pkg::PRI_CHOOSE;
                    end
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_PRI_REF, v, 1'b0);
                        n_step = fhp_pkg::S_BROVW;
                    end
                end
                fhp_pkg::S_BROVW: begin
                    if (bridge) begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        o_push = ok;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_BR_OVW, gv, 1'b0);
                        if (ok) n_fl.ovw = gv[0];
                    end
                    if (ok) n_step = fhp_pkg::S_REFRESH;
                end
                fhp_pkg::S_REFRESH: begin
                    n_step = fhp_pkg::S_SIZE;
                    if (r_fl.ft == fhp_pkg::FT_KEY) begin
                        if (r_kind == fhp_pkg::K_CLEAN && i_cfg.seq_flags[fhp_pkg::SF_ONELAYER]) begin
                            o_push = 1'b1;
                            o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH,
                                                    {15'd0, all_mask}, 1'b0);
                        end else begin
                            n_step = i_cfg.seq_flags[fhp_pkg::SF_SHORTREF] ? fhp_pkg::S_FTR
                                                                           : fhp_pkg::S_RFULL;
                        end
                    end else if (bridge && !r_fl.ovw) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH,
                                                32'd1 << r_bslot, 1'b0);
                    end else if (r_kind == fhp_pkg::K_RA &&
                                 i_cfg.seq_flags[fhp_pkg::SF_ONELAYER]) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH, 32'd0, 1'b0);
                    end else if (r_fl.ft == fhp_pkg::FT_SWITCH) begin
                        n_step = fhp_pkg::S_RFULL;
                    end else begin
                        n_step = i_cfg.seq_flags[fhp_pkg::SF_SHORTREF] ? fhp_pkg::S_HASREF
                                                                       : fhp_pkg::S_RFULL;
                    end
                end
                fhp_pkg::S_HASREF: begin
                    need = 1'b1; want = 6'd1; ok = r_ready;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_HAS_REF, gv, 1'b0);
                        n_step = gv[0] ? fhp_pkg::S_FTR : fhp_pkg::S_REF_NONE;
                    end
                end
                fhp_pkg::S_REF_NONE: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH, 32'd0, 1'b0);
                    n_step = fhp_pkg::S_SIZE;
                end
                fhp_pkg::S_FTR: begin
                    need = 1'b1; want = slot_bits; ok = r_ready || want == 6'd0;
                    if (ok) begin
                        n_hold = gv;
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_FTR, gv, 1'b0);
                        n_step = fhp_pkg::S_FTR_MASK;
                    end
                end
                fhp_pkg::S_FTR_MASK: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH, 32'd1 << r_hold[3:0], 1'b0);
                    n_step = fhp_pkg::S_SIZE;
                end
                fhp_pkg::S_RFULL: begin
                    need = 1'b1; want = {1'b0, slots}; ok = r_ready || want == 6'd0;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REFRESH, gv, 1'b0);
                        n_step = fhp_pkg::S_SIZE;
                    end
                end
                fhp_pkg::S_SIZE: begin
                    if (r_fl.intra) begin
                        n_step = r_fl.ovr ? fhp_pkg::S_W : fhp_pkg::S_DEF_W;
                    end else begin
                        n_step = fhp_pkg::S_EXPL;
                    end
                end
                fhp_pkg::S_W: begin
                    need = 1'b1; want = fhp_pkg::f_fbits(i_cfg.w_bits); ok = r_ready;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_WIDTH, gv + 32'd1, 1'b0);
                        n_step = fhp_pkg::S_H;
                    end
                end
                fhp_pkg::S_H: begin
                    need = 1'b1; want = fhp_pkg::f_fbits(i_cfg.h_bits); ok = r_ready;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_HEIGHT, gv + 32'd1, 1'b0);
                        n_step = r_fl.intra ? fhp_pkg::S_FIN_INTRA : fhp_pkg::S_BRU;
                    end
                end
                fhp_pkg::S_DEF_W: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_WIDTH, {15'd0, i_cfg.max_w}, 1'b0);
                    n_step = fhp_pkg::S_DEF_H;
                end
                fhp_pkg::S_DEF_H: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_HEIGHT, {15'd0, i_cfg.max_h}, 1'b0);
                    n_step = (r_fl.intra || r_fl.sef) ? fhp_pkg::S_FIN_INTRA
                                                      : fhp_pkg::S_BRU;
                end
                fhp_pkg::S_EXPL: begin
                    if (r_fl.ft == fhp_pkg::FT_SWITCH || bridge) begin
                        v = 32'd1;
                    end else if (i_cfg.seq_flags[fhp_pkg::SF_EXPLMAP]) begin
                        need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                    end else begin
                        v = 32'd0;
                    end
                    if (ok) begin
                        n_fl.expl = v[0];
                        o_push    = 1'b1;
                        o_rec     = fhp_pkg::f_rec(fhp_pkg::EC_EXPL_MAP, v, 1'b0);
                        n_step    = fhp_pkg::S_NREFS;
                    end
                end
                fhp_pkg::S_NREFS: begin
                    if (bridge) begin
                        v = 32'd1;
                    end else if (r_fl.expl) begin
                        need = 1'b1; want = 6'd3; ok = r_ready; v = gv;
                    end else begin
                        v = 32'd0;
                    end
                    if (ok) begin
                        n_refc = v[2:0];
                        n_loop = 4'd0;
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_NUM_REFS, {29'd0, v[2:0]}, 1'b0);
                        n_step = fhp_pkg::S_REFIDX;
                    end
                end
                fhp_pkg::S_REFIDX: begin
                    if (r_loop >= {1'b0, r_refc}) begin
                        n_step = fhp_pkg::S_FSZ;
                    end else begin
                        if (bridge) begin
                            v = {28'd0, r_bslot};
                        end else begin
                            need = 1'b1; want = slot_bits; ok = r_ready || want == 6'd0;
                            v = gv;
                        end
                        if (ok) begin
                            o_push = 1'b1;
                            o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_REF_IDX, v, 1'b0);
                            n_loop = r_loop + 4'd1;
                        end
                    end
                end
                fhp_pkg::S_FSZ: begin
                    if (bridge) begin
                        n_step = fhp_pkg::S_W;
                    end else if (r_fl.ovr && r_fl.ft != fhp_pkg::FT_SWITCH) begin
                        n_loop = 4'd0;
                        n_step = fhp_pkg::S_FOUND;
                    end else if (r_fl.ovr) begin
                        n_step = fhp_pkg::S_W;
                    end else begin
                        n_step = fhp_pkg::S_DEF_W;
                    end
                end
                fhp_pkg::S_FOUND: begin
                    if (r_loop >= {1'b0, r_refc}) begin
                        n_step = fhp_pkg::S_W;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        if (ok) begin
                            o_push = 1'b1;
                            o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_FOUND_REF, gv, 1'b0);
                            if (gv[0]) n_step = fhp_pkg::S_DEF_W;
                            else       n_loop = r_loop + 4'd1;
                        end
                    end
                end
                fhp_pkg::S_BRU: begin
                    if (i_cfg.seq_flags[fhp_pkg::SF_BRU] && r_fl.ft == fhp_pkg::FT_INTER &&
                        r_kind != fhp_pkg::K_TIP && !bridge) begin
                        need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                    end else begin
                        v = 32'd0;
                    end
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_USE_BRU, v, 1'b0);
                        n_step = v[0] ? fhp_pkg::S_BRUREF : fhp_pkg::S_MVS;
                    end
                end
                fhp_pkg::S_BRUREF: begin
                    need = 1'b1; want = fhp_pkg::f_clog2({2'b00, r_refc});
                    ok = r_ready || want == 6'd0;
                    if (ok) begin
                        o_push = 1'b1;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_BRU_REF, gv, 1'b0);
                        n_step = fhp_pkg::S_BRUINACT;
                    end
                end
                fhp_pkg::S_BRUINACT: begin
                    need = 1'b1; want = 6'd1; ok = r_ready;
                    if (ok) begin
                        n_fl.bruin = gv[0];
                        o_push     = 1'b1;
                        o_rec      = fhp_pkg::f_rec(fhp_pkg::EC_BRU_INACT, gv, 1'b0);
                        n_step     = fhp_pkg::S_MVS;
                    end
                end
                fhp_pkg::S_MVS: begin
                    if (r_fl.ft == fhp_pkg::FT_SWITCH || !i_cfg.seq_flags[fhp_pkg::SF_REFMVS] ||
                        bridge || r_fl.bruin) begin
                        v = 32'd0;
                    end else begin
                        need = 1'b1; want = 6'd1; ok = r_ready; v = gv;
                    end
                    if (ok) begin
                        n_fl.mvs = v[0];
                        o_push   = 1'b1;
                        o_rec    = fhp_pkg::f_rec(fhp_pkg::EC_USE_MVS, v, 1'b0);
                        n_step   = fhp_pkg::S_TMVP;
                    end
                end
                fhp_pkg::S_TMVP: begin
                    if (r_fl.mvs && r_refc > 3'd1 && (i_cfg.seq_flags[fhp_pkg::SF_SB256] ||
                                                      i_cfg.seq_flags[fhp_pkg::SF_SB128])) begin
                        need = 1'b1; want = 6'd1; ok = r_ready;
                        o_push = ok;
                        o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_TMVP_STEP, gv, 1'b0);
                    end
                    if (ok) n_step = fhp_pkg::S_FIN_INTRA;
                end
                fhp_pkg::S_FIN_INTRA: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_IS_INTRA, {31'd0, r_fl.intra}, 1'b0);
                    n_step = fhp_pkg::S_FIN_SEF;
                end
                fhp_pkg::S_FIN_SEF: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_SHOW_EXIST, {31'd0, r_fl.sef}, 1'b0);
                    n_step = fhp_pkg::S_FIN_OUT;
                end
                fhp_pkg::S_FIN_OUT: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_IS_OUTPUT,
                                            {31'd0, r_fl.imm | r_fl.impl}, 1'b0);
                    n_step = fhp_pkg::S_FIN_TIP;
                end
                fhp_pkg::S_FIN_TIP: begin
                    o_push = 1'b1;
                    o_rec  = fhp_pkg::f_rec(fhp_pkg::EC_TIP_MODE, 32'd0, 1'b1);
                    n_step = fhp_pkg::S_IDLE;
                end
                default: begin
                    n_step = fhp_pkg::S_IDLE;
                end
            endcase
            // field fetch bookkeeping
            if (need) begin
                n_acc = 32'd0;
                if (r_ready)             n_ready = 1'b0;
                else if (want != 6'd0)   n_cnt   = want;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= fhp_pkg::S_IDLE;
            r_cnt   <= 6'd0;
            r_kind  <= 3'd0;
            r_fl    <= '0;
            r_refc  <= 3'd0;
            r_loop  <= 4'd0;
            r_bslot <= 4'd0;
            r_uvz   <= 6'd0;
            r_uvph  <= 1'b0;
            r_ready <= 1'b0;
        end else begin
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_fl    <= n_fl;
            r_refc  <= n_refc;
            r_loop  <= n_loop;
            r_bslot <= n_bslot;
            r_uvz   <= n_uvz;
            r_uvph  <= n_uvph;
            r_ready <= n_ready;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_hold <= n_hold;
    end

endmodule

`default_nettype wire

[hdl/fhp_queue.sv]
// ----------------------------------------------------------------------------
// fhp_queue
// short record queue between the sequencer and the output stream
// ----------------------------------------------------------------------------
`default_nettype none

module fhp_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire fhp_pkg::t_rec i_rec,
    output logic               o_full,
    output logic               o_valid,
    output fhp_pkg::t_rec      o_rec,
    input  wire logic          i_ready
);

    localparam int PW = $clog2(fhp_pkg::QDEPTH);
    localparam int CW = $clog2(fhp_pkg::QDEPTH + 1);

    fhp_pkg::t_rec r_mem [fhp_pkg::QDEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          pop;

    assign o_full  = (r_cnt == CW'(fhp_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + PW'(1);
            if (pop)    r_rd <= r_rd + PW'(1);
            if (i_push && !pop)      r_cnt <= r_cnt + CW'(1);
            else if (pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

`default_nettype wire

[bench/frame_header_field_parser_test.sv]
// ----------------------------------------------------------------------------
// frame_header_field_parser_test
// self-checking bench for the bit-serial frame header parser
// ----------------------------------------------------------------------------
// Start and bit words go in on the slave stream. A behavioural copy of the
// parser works out the records each accepted word should cause. Every record
// on the master stream is compared with the oldest pending one. A directed
// table runs first, then random headers under several register settings and
// several idling patterns.
`timescale 1ns / 1ps
`default_nettype none

module frame_header_field_parser_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int PHASE_WORDS    = 12;
    localparam int NUM_PHASES     = 6;

    localparam int unsigned HF_BRIDGE = 32'h001;
    localparam int unsigned HF_INTRA  = 32'h002;
    localparam int unsigned HF_IMM    = 32'h004;
    localparam int unsigned HF_IMPL   = 32'h008;
    localparam int unsigned HF_OVR    = 32'h010;
    localparam int unsigned HF_OVW    = 32'h020;
    localparam int unsigned HF_EXPL   = 32'h040;
    localparam int unsigned HF_BRUIN  = 32'h080;
    localparam int unsigned HF_MVS    = 32'h100;
    localparam int unsigned HF_SIGPRI = 32'h200;
    localparam int unsigned HF_SEF    = 32'h400;

    typedef enum int {
        P_IDLE, P_MFH, P_SEQ, P_BIDX, P_MODE, P_SHOW, P_DOH, P_SOH, P_GRAIN, P_FGM,
        P_SEED, P_SEFEND, P_FTYPE, P_LTID, P_NKEY, P_KEYREF, P_IMM, P_IMPL, P_OVR,
        P_OH, P_PRI, P_CDF, P_PRIVAL, P_BROVW, P_REFRESH, P_HASREF, P_FTR, P_RFULL,
        P_SIZE, P_W, P_H, P_EXPL, P_NREFS, P_REFIDX, P_FSZ, P_FOUND, P_BRU,
        P_BRUREF, P_BRUINACT, P_MVS, P_TMVP, P_FINAL
    } t_pstep;

    typedef struct {
        logic [5:0]  code;
        logic [31:0] value;
        logic        last;
    } t_hdr_rec;

    typedef struct {
        bit          st;
        logic [2:0]  kind;
        bit          b;
        bit          chk;
        logic [5:0]  code;
        logic [31:0] value;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;  // unit_kind[2:0], bit_req[3], zero pad
    logic [0:0]  s_tuser;  // start_req[0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;  // element_code[5:0], element_value[37:6], pad
    logic        m_tlast;  // header_done

    frame_header_field_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // register copies
    logic [9:0]  cf_flags;
    logic [4:0]  cf_slots;
    logic [3:0]  cf_ohw;
    logic [3:0]  cf_ltw;
    logic [4:0]  cf_wb;
    logic [4:0]  cf_hb;
    logic [16:0] cf_maxw;
    logic [16:0] cf_maxh;

    // parser state copy
    t_pstep      p_step;
    int unsigned p_cnt, p_acc, p_kind, p_flags, p_refs, p_loop, p_bslot;
    int unsigned uv_zeros, uv_phase;
    bit          p_ready;

    t_hdr_rec expected_records[$];
    t_hdr_rec word_records[$];

    int errors        = 0;
    int records_seen  = 0;
    int words_sent    = 0;
    int headers_begun = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req      = 0;

    function automatic void emit_rec(logic [5:0] c, int unsigned v, bit l);
        t_hdr_rec r;
        if (word_records.size() >= 16) return;
        r.code  = c;
        r.value = v;
        r.last  = l;
        word_records.push_back(r);
        expected_records.push_back(r);
    endfunction

    function automatic int unsigned slot_count();
        return (cf_slots > 16) ? 16 : cf_slots;
    endfunction

    function automatic int unsigned hint_bits();
        return (cf_ohw > fhp_pkg::OH_MAX) ? fhp_pkg::OH_MAX : cf_ohw;
    endfunction

    function automatic int unsigned size_bits(logic [4:0] b);
        return (b < 1) ? 1 : ((b > 16) ? 16 : b);
    endfunction

    function automatic int unsigned ceil_log2(int unsigned n);
        int unsigned k;
        k = 0;
        while (k < 5 && (32'd1 << k) < n) k++;
        return k;
    endfunction

    function automatic bit has_flag(int unsigned m);
        return (p_flags & m) != 0;
    endfunction

    function automatic void set_flag(int unsigned m, bit on);
        if (on) p_flags = p_flags | m;
        else p_flags = p_flags & ~m;
    endfunction

    function automatic bit take_bits(int unsigned k);
        if (p_ready) begin
            p_ready = 0;
            return 1;
        end
        p_acc = 0;
        if (k == 0) return 1;
        p_cnt = k;
        return 0;
    endfunction

    function automatic bit take_uvlc(output int unsigned v);
        v = 0;
        forever begin
            if (uv_phase == 0) begin
                if (!take_bits(1)) return 0;
                if (p_acc == 0) begin
                    if (uv_zeros < 32) uv_zeros++;
                    continue;
                end
                if (uv_zeros >= 32) begin
                    v = 32'hFFFF_FFFF;
                    uv_zeros = 0;
                    return 1;
                end
                uv_phase = 1;
            end
            if (!take_bits(uv_zeros)) return 0;
            v = p_acc + ((32'd1 << uv_zeros) - 1);
            uv_phase = 0;
            uv_zeros = 0;
            return 1;
        end
    endfunction

    function automatic void emit_default_size();
        emit_rec(fhp_pkg::EC_WIDTH, cf_maxw, 0);
        emit_rec(fhp_pkg::EC_HEIGHT, cf_maxh, 0);
    endfunction

    function automatic void advance_header();
        int unsigned v, ft;
        bit br;
        forever begin
            br = has_flag(HF_BRIDGE);
            ft = (p_flags >> 14) & 3;
            case (p_step)
                P_MFH: begin
                    if (br) begin
                        emit_rec(fhp_pkg::EC_MFH_ID, 0, 0);
                        p_step = P_SEQ;
                    end else begin
                        if (!take_uvlc(v)) return;
                        emit_rec(fhp_pkg::EC_MFH_ID, v, 0);
                        p_step = (v == 0) ? P_SEQ : P_BIDX;
                    end
                end
                P_SEQ: begin
                    if (!take_uvlc(v)) return;
                    emit_rec(fhp_pkg::EC_SEQ_ID, v, 0);
                    p_step = P_BIDX;
                end
                P_BIDX: begin
                    if (br) begin
                        if (!take_bits(ceil_log2(slot_count()))) return;
                        p_bslot = p_acc & 15;
                        emit_rec(fhp_pkg::EC_BRIDGE_IDX, p_bslot, 0);
                    end
                    p_step = P_MODE;
                end
                P_MODE: begin
                    if (cf_flags[fhp_pkg::SF_SINGLE]) begin
                        p_flags = p_flags & 32'h3FFF;
                        set_flag(HF_INTRA, 1);
                        set_flag(HF_IMM, 1);
                        set_flag(HF_IMPL, 0);
                        emit_rec(fhp_pkg::EC_FTYPE, fhp_pkg::FT_KEY, 0);
                        emit_rec(fhp_pkg::EC_IMM_OUT, 1, 0);
                        emit_rec(fhp_pkg::EC_IMPL_OUT, 0, 0);
                        p_step = P_OVR;
                    end else if (p_kind == fhp_pkg::K_SHOW) begin
                        set_flag(HF_SEF, 1);
                        set_flag(HF_IMM, 1);
                        p_step = P_SHOW;
                    end else begin
                        p_step = P_FTYPE;
                    end
                end
                P_SHOW: begin
                    if (!take_bits(ceil_log2(slot_count()))) return;
                    emit_rec(fhp_pkg::EC_SHOW_IDX, p_acc, 0);
                    p_step = P_DOH;
                end
                P_DOH: begin
                    if (!take_bits(1)) return;
                    emit_rec(fhp_pkg::EC_DERIVE_OH, p_acc, 0);
                    p_step = (p_acc != 0) ? P_GRAIN : P_SOH;
                end
                P_SOH: begin
                    if (!take_bits(hint_bits())) return;
                    emit_rec(fhp_pkg::EC_SEF_OH, p_acc, 0);
                    p_step = P_GRAIN;
                end
                P_GRAIN: begin
                    if (!cf_flags[fhp_pkg::SF_GRAIN] ||
                            (!has_flag(HF_IMM) && !has_flag(HF_IMPL)))
                        v = 0;
                    else if (cf_flags[fhp_pkg::SF_SINGLE]) v = 1;
                    else begin
                        if (!take_bits(1)) return;
                        v = p_acc;
                    end
                    emit_rec(fhp_pkg::EC_APPLY_FG, v, 0);
                    p_step = (v != 0) ? P_FGM : P_SEFEND;
                end
                P_FGM: begin
                    if (!take_bits(3)) return;
                    emit_rec(fhp_pkg::EC_FG_MODEL, p_acc, 0);
                    p_step = P_SEED;
                end
                P_SEED: begin
                    if (!take_bits(16)) return;
                    emit_rec(fhp_pkg::EC_FG_SEED, p_acc, 0);
                    p_step = P_SEFEND;
                end
                P_SEFEND: begin
                    emit_rec(fhp_pkg::EC_REFRESH, 0, 0);
                    emit_default_size();
                    p_step = P_FINAL;
                end
                P_FTYPE: begin
                    if (br || p_kind == fhp_pkg::K_TIP) ft = fhp_pkg::FT_INTER;
                    else if (p_kind == fhp_pkg::K_SWITCH || p_kind == fhp_pkg::K_RA) begin
                        if (!take_bits(1)) return;
                        emit_rec(fhp_pkg::EC_RESTR_SW, p_acc, 0);
                        ft = fhp_pkg::FT_SWITCH;
                    end else if (p_kind == fhp_pkg::K_CLEAN || p_kind == fhp_pkg::K_OPEN)
                        ft = fhp_pkg::FT_KEY;
                    else begin
                        if (!take_bits(1)) return;
                        emit_rec(fhp_pkg::EC_IS_INTER, p_acc, 0);
                        ft = (p_acc != 0) ? fhp_pkg::FT_INTER : fhp_pkg::FT_INTRA;
                    end
                    p_flags = (p_flags & 32'h3FFF) | ((ft & 3) << 14);
                    set_flag(HF_INTRA, ft == fhp_pkg::FT_KEY || ft == fhp_pkg::FT_INTRA);
                    emit_rec(fhp_pkg::EC_FTYPE, ft, 0);
                    p_step = P_LTID;
                end
                P_LTID: begin
                    if (ft == fhp_pkg::FT_KEY && cf_ltw > 0) begin
                        if (!take_bits(cf_ltw)) return;
                        emit_rec(fhp_pkg::EC_LTID_P1, p_acc, 0);
                        emit_rec(fhp_pkg::EC_LTID, p_acc - 1, 0);
                    end
                    p_step = P_NKEY;
                end
                P_NKEY: begin
                    p_step = P_IMM;
                    if ((p_kind == fhp_pkg::K_RA || p_kind == fhp_pkg::K_OPEN)
                            && cf_ltw != 0) begin
                        if (!take_bits(3)) begin
                            p_step = P_NKEY;
                            return;
                        end
                        emit_rec(fhp_pkg::EC_NUM_KEY, p_acc, 0);
                        p_loop = p_acc & 7;
                        if (p_loop > 0) p_step = P_KEYREF;
                    end
                end
                P_KEYREF: begin
                    if (!take_bits(cf_ltw)) return;
                    emit_rec(fhp_pkg::EC_REF_LTID, p_acc, 0);
                    p_loop = (p_loop - 1) & 15;
                    if (p_loop == 0) p_step = P_IMM;
                end
                P_IMM: begin
                    if (br || p_kind == fhp_pkg::K_OPEN) v = 0;
                    else begin
                        if (!take_bits(1)) return;
                        v = p_acc;
                    end
                    set_flag(HF_IMM, v != 0);
                    emit_rec(fhp_pkg::EC_IMM_OUT, v, 0);
                    p_step = P_IMPL;
                end
                P_IMPL: begin
                    if (br || has_flag(HF_IMM) || cf_flags[fhp_pkg::SF_MONO]) v = 0;
                    else begin
                        if (!take_bits(1)) return;
                        v = p_acc;
                    end
                    set_flag(HF_IMPL, v != 0);
                    emit_rec(fhp_pkg::EC_IMPL_OUT, v, 0);
                    p_step = P_OVR;
                end
                P_OVR: begin
                    if (br) begin
                        emit_rec(fhp_pkg::EC_ORDER_HINT, 0, 0);
                        emit_rec(fhp_pkg::EC_PRI_REF, fhp_pkg::PRI_NONE, 0);
                        p_step = P_BROVW;
                    end else begin
                        if (ft == fhp_pkg::FT_SWITCH) v = 1;
                        else if (cf_flags[fhp_pkg::SF_SINGLE]) v = 0;
                        else begin
                            if (!take_bits(1)) return;
                            v = p_acc;
                        end
                        set_flag(HF_OVR, v != 0);
                        emit_rec(fhp_pkg::EC_SIZE_OVR, v, 0);
                        p_step = P_OH;
                    end
                end
                P_OH: begin
                    if (!take_bits(hint_bits())) return;
                    emit_rec(fhp_pkg::EC_ORDER_HINT, p_acc, 0);
                    p_step = P_PRI;
                end
                P_PRI: begin
                    if (has_flag(HF_INTRA) || ft == fhp_pkg::FT_SWITCH) begin
                        emit_rec(fhp_pkg::EC_PRI_REF, fhp_pkg::PRI_NONE, 0);
                        p_step = P_BROVW;
                    end else begin
                        if (!take_bits(1)) return;
                        set_flag(HF_SIGPRI, p_acc != 0);
                        emit_rec(fhp_pkg::EC_SIG_PRI, p_acc, 0);
                        p_step = P_CDF;
                    end
                end
                P_CDF: begin
                    if (p_kind != fhp_pkg::K_TIP) begin
                        if (!take_bits(1)) return;
                        emit_rec(fhp_pkg::EC_DIS_CDF, p_acc, 0);
                    end
                    p_step = P_PRIVAL;
                end
                P_PRIVAL: begin
                    if (has_flag(HF_SIGPRI)) begin
                        if (!take_bits(3)) return;
                        emit_rec(fhp_pkg::EC_PRI_REF, p_acc, 0);
                    end else begin
                        emit_rec(fhp_pkg::EC_PRI_REF, fhp_pkg::PRI_CHOOSE, 0);
                    end
                    p_step = P_BROVW;
                end
                P_BROVW: begin
                    if (br) begin
                        if (!take_bits(1)) return;
                        set_flag(HF_OVW, p_acc != 0);
                        emit_rec(fhp_pkg::EC_BR_OVW, p_acc, 0);
                    end
                    p_step = P_REFRESH;
                end
                P_REFRESH: begin
                    p_step = P_SIZE;
                    if (ft == fhp_pkg::FT_KEY) begin
                        if (p_kind == fhp_pkg::K_CLEAN && cf_flags[fhp_pkg::SF_ONELAYER])
                            emit_rec(fhp_pkg::EC_REFRESH, (32'd1 << slot_count()) - 1, 0);
                        else p_step = cf_flags[fhp_pkg::SF_SHORTREF] ? P_FTR : P_RFULL;
                    end else if (br && !has_flag(HF_OVW)) begin
                        emit_rec(fhp_pkg::EC_REFRESH, 32'd1 << (p_bslot & 15), 0);
                    end else if (p_kind == fhp_pkg::K_RA && cf_flags[fhp_pkg::SF_ONELAYER]) begin
                        emit_rec(fhp_pkg::EC_REFRESH, 0, 0);
                    end else if (ft == fhp_pkg::FT_SWITCH) begin
                        p_step = P_RFULL;
                    end else begin
                        p_step = cf_flags[fhp_pkg::SF_SHORTREF] ? P_HASREF : P_RFULL;
                    end
                end
                P_HASREF: begin
                    if (!take_bits(1)) return;
                    emit_rec(fhp_pkg::EC_HAS_REF, p_acc, 0);
                    if (p_acc != 0) p_step = P_FTR;
                    else begin
                        emit_rec(fhp_pkg::EC_REFRESH, 0, 0);
                        p_step = P_SIZE;
                    end
                end
                P_FTR: begin
                    if (!take_bits(ceil_log2(slot_count()))) return;
                    emit_rec(fhp_pkg::EC_FTR, p_acc, 0);
                    emit_rec(fhp_pkg::EC_REFRESH, 32'd1 << (p_acc & 15), 0);
                    p_step = P_SIZE;
                end
                P_RFULL: begin
                    if (!take_bits(slot_count())) return;
                    emit_rec(fhp_pkg::EC_REFRESH, p_acc, 0);
                    p_step = P_SIZE;
                end
                P_SIZE: begin
                    if (has_flag(HF_INTRA)) begin
                        if (has_flag(HF_OVR)) p_step = P_W;
                        else begin
                            emit_default_size();
                            p_step = P_FINAL;
                        end
                    end else begin
                        p_step = P_EXPL;
                    end
                end
                P_W: begin
                    if (!take_bits(size_bits(cf_wb))) return;
                    emit_rec(fhp_pkg::EC_WIDTH, p_acc + 1, 0);
                    p_step = P_H;
                end
                P_H: begin
                    if (!take_bits(size_bits(cf_hb))) return;
                    emit_rec(fhp_pkg::EC_HEIGHT, p_acc + 1, 0);
                    p_step = has_flag(HF_INTRA) ? P_FINAL : P_BRU;
                end
                P_EXPL: begin
                    if (ft == fhp_pkg::FT_SWITCH || br) v = 1;
                    else if (cf_flags[fhp_pkg::SF_EXPLMAP]) begin
                        if (!take_bits(1)) return;
                        v = p_acc;
                    end else v = 0;
                    set_flag(HF_EXPL, v != 0);
                    emit_rec(fhp_pkg::EC_EXPL_MAP, v, 0);
                    p_step = P_NREFS;
                end
                P_NREFS: begin
                    if (br) v = 1;
                    else if (has_flag(HF_EXPL)) begin
                        if (!take_bits(3)) return;
                        v = p_acc;
                    end else v = 0;
                    p_refs = v & 7;
                    p_loop = 0;
                    emit_rec(fhp_pkg::EC_NUM_REFS, p_refs, 0);
                    p_step = P_REFIDX;
                end
                P_REFIDX: begin
                    if (p_loop >= p_refs) p_step = P_FSZ;
                    else begin
                        if (br) v = p_bslot;
                        else begin
                            if (!take_bits(ceil_log2(slot_count()))) return;
                            v = p_acc;
                        end
                        emit_rec(fhp_pkg::EC_REF_IDX, v, 0);
                        p_loop = (p_loop + 1) & 15;
                    end
                end
                P_FSZ: begin
                    if (br) p_step = P_W;
                    else if (has_flag(HF_OVR) && ft != fhp_pkg::FT_SWITCH) begin
                        p_loop = 0;
                        p_step = P_FOUND;
                    end else if (has_flag(HF_OVR)) p_step = P_W;
                    else begin
                        emit_default_size();
                        p_step = P_BRU;
                    end
                end
                P_FOUND: begin
                    if (p_loop >= p_refs) p_step = P_W;
                    else begin
                        if (!take_bits(1)) return;
                        emit_rec(fhp_pkg::EC_FOUND_REF, p_acc, 0);
                        if (p_acc != 0) begin
                            emit_default_size();
                            p_step = P_BRU;
                        end else p_loop = (p_loop + 1) & 15;
                    end
                end
                P_BRU: begin
                    p_step = P_MVS;
                    if (cf_flags[fhp_pkg::SF_BRU] && ft == fhp_pkg::FT_INTER
                            && p_kind != fhp_pkg::K_TIP && !br) begin
                        if (!take_bits(1)) begin
                            p_step = P_BRU;
                            return;
                        end
                        emit_rec(fhp_pkg::EC_USE_BRU, p_acc, 0);
                        if (p_acc != 0) p_step = P_BRUREF;
                    end else begin
                        emit_rec(fhp_pkg::EC_USE_BRU, 0, 0);
                    end
                end
                P_BRUREF: begin
                    if (!take_bits(ceil_log2(p_refs))) return;
                    emit_rec(fhp_pkg::EC_BRU_REF, p_acc, 0);
                    p_step = P_BRUINACT;
                end
                P_BRUINACT: begin
                    if (!take_bits(1)) return;
                    set_flag(HF_BRUIN, p_acc != 0);
                    emit_rec(fhp_pkg::EC_BRU_INACT, p_acc, 0);
                    p_step = P_MVS;
                end
                P_MVS: begin
                    if (ft == fhp_pkg::FT_SWITCH || !cf_flags[fhp_pkg::SF_REFMVS] || br
                            || has_flag(HF_BRUIN))
                        v = 0;
                    else begin
                        if (!take_bits(1)) return;
                        v = p_acc;
                    end
                    set_flag(HF_MVS, v != 0);
                    emit_rec(fhp_pkg::EC_USE_MVS, v, 0);
                    p_step = P_TMVP;
                end
                P_TMVP: begin
                    if (has_flag(HF_MVS) && p_refs > 1
                            && (cf_flags[fhp_pkg::SF_SB256] || cf_flags[fhp_pkg::SF_SB128])) begin
                        if (!take_bits(1)) return;
                        emit_rec(fhp_pkg::EC_TMVP_STEP, p_acc, 0);
                    end
                    p_step = P_FINAL;
                end
                P_FINAL: begin
                    emit_rec(fhp_pkg::EC_IS_INTRA, has_flag(HF_INTRA), 0);
                    emit_rec(fhp_pkg::EC_SHOW_EXIST, has_flag(HF_SEF), 0);
                    emit_rec(fhp_pkg::EC_IS_OUTPUT, has_flag(HF_IMM) || has_flag(HF_IMPL), 0);
                    emit_rec(fhp_pkg::EC_TIP_MODE, 0, 1);
                    p_step = P_IDLE;
                    return;
                end
                default: begin
                    p_step = P_IDLE;
                    return;
                end
            endcase
        end
    endfunction

    function automatic void predict_word(bit st, logic [2:0] kind, bit b);
        word_records.delete();
        if (st) begin
            p_kind = kind;
            p_flags = (kind == fhp_pkg::K_BRIDGE) ? HF_BRIDGE : 0;
            p_cnt = 0; p_acc = 0; p_refs = 0; p_loop = 0; p_bslot = 0;
            uv_zeros = 0; uv_phase = 0; p_ready = 0;
            p_step = P_MFH;
            headers_begun++;
            advance_header();
        end else if (p_step != P_IDLE && p_cnt > 0) begin
            p_acc = (p_acc << 1) | b;
            p_cnt--;
            if (p_cnt == 0) begin
                p_ready = 1;
                advance_header();
            end
        end
    endfunction

    task automatic send_word(bit st, logic [2:0] kind, bit b);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, b, kind};
        s_tuser  <= st;
        do @(posedge i_clk); while (!s_tready);
        predict_word(st, kind, b);
        words_sent++;
    endtask

    task automatic send_random_bit();
        send_word(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)));
    endtask

    task automatic finish_header();
        while (p_step != P_IDLE) send_random_bit();
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            fhp_pkg::RI_SEQ_FLAGS: cf_flags = val[9:0];
            fhp_pkg::RI_NUM_SLOTS: cf_slots = val[4:0];
            fhp_pkg::RI_OH_WIDTH:  cf_ohw   = val[3:0];
            fhp_pkg::RI_LT_WIDTH:  cf_ltw   = val[3:0];
            fhp_pkg::RI_W_BITS:    cf_wb    = val[4:0];
            fhp_pkg::RI_H_BITS:    cf_hb    = val[4:0];
            fhp_pkg::RI_MAX_W:     cf_maxw  = val[16:0];
            fhp_pkg::RI_MAX_H:     cf_maxh  = val[16:0];
            default: ;
        endcase
    endtask

    task automatic configure_phase(int ph);
        case (ph)
            0: begin
                write_reg(fhp_pkg::RI_SEQ_FLAGS, 1023); write_reg(fhp_pkg::RI_NUM_SLOTS, 16);
                write_reg(fhp_pkg::RI_OH_WIDTH, 8);     write_reg(fhp_pkg::RI_LT_WIDTH, 15);
                write_reg(fhp_pkg::RI_W_BITS, 16);      write_reg(fhp_pkg::RI_H_BITS, 16);
                write_reg(fhp_pkg::RI_MAX_W, 65536);    write_reg(fhp_pkg::RI_MAX_H, 65536);
            end
            1: begin
                write_reg(fhp_pkg::RI_SEQ_FLAGS, 0);    write_reg(fhp_pkg::RI_NUM_SLOTS, 1);
                write_reg(fhp_pkg::RI_OH_WIDTH, 0);     write_reg(fhp_pkg::RI_LT_WIDTH, 0);
                write_reg(fhp_pkg::RI_W_BITS, 1);       write_reg(fhp_pkg::RI_H_BITS, 1);
                write_reg(fhp_pkg::RI_MAX_W, 1);        write_reg(fhp_pkg::RI_MAX_H, 1);
            end
            2: begin
                write_reg(fhp_pkg::RI_SEQ_FLAGS, $urandom_range(1023));
                write_reg(fhp_pkg::RI_NUM_SLOTS, 31);   write_reg(fhp_pkg::RI_OH_WIDTH, 15);
                write_reg(fhp_pkg::RI_LT_WIDTH, $urandom_range(15));
                write_reg(fhp_pkg::RI_W_BITS, 0);       write_reg(fhp_pkg::RI_H_BITS, 31);
                write_reg(fhp_pkg::RI_MAX_W, 0);        write_reg(fhp_pkg::RI_MAX_H, 131071);
            end
            default: begin
                write_reg(fhp_pkg::RI_SEQ_FLAGS, $urandom_range(1023));
                write_reg(fhp_pkg::RI_NUM_SLOTS, (ph == 3) ? 0 : $urandom_range(1, 16));
                write_reg(fhp_pkg::RI_OH_WIDTH, $urandom_range(8));
                write_reg(fhp_pkg::RI_LT_WIDTH, $urandom_range(15));
                write_reg(fhp_pkg::RI_W_BITS, $urandom_range(1, 8));
                write_reg(fhp_pkg::RI_H_BITS, $urandom_range(1, 8));
                write_reg(fhp_pkg::RI_MAX_W, $urandom_range(1, 65536));
                write_reg(fhp_pkg::RI_MAX_H, $urandom_range(1, 65536));
            end
        endcase
    endtask

    // directed words, default register values
    t_dir_row dir_rows[] = '{
        '{1, fhp_pkg::K_BRIDGE, 1, 1, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_SHOW,   0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   1, 1, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   1, 1, fhp_pkg::EC_SEQ_ID, 0},
        '{0, fhp_pkg::K_RA,     1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_SHOW,   1, 1, fhp_pkg::EC_SHOW_IDX, 5},
        '{0, fhp_pkg::K_TILE,   1, 1, fhp_pkg::EC_DERIVE_OH, 1},
        '{0, fhp_pkg::K_SHOW,   1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_CLEAN,  0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   1, 1, fhp_pkg::EC_MFH_ID, 2},
        '{0, fhp_pkg::K_TILE,   1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_TILE,   1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   1, 1, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TILE,   0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_SWITCH, 0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_CLEAN,  1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_RA,     0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_OPEN,   0, 0, fhp_pkg::EC_MFH_ID, 0},
        '{1, fhp_pkg::K_TIP,    1, 0, fhp_pkg::EC_MFH_ID, 0},
        '{0, fhp_pkg::K_TIP,    1, 0, fhp_pkg::EC_MFH_ID, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side, with one long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                repeat (300) begin
                    m_tready <= 1'b0;
                    @(negedge i_clk);
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_hdr_rec want;
        if (i_rst_n && m_tvalid && m_tready) begin
            records_seen++;
            if (expected_records.size() == 0) begin
                errors++;
                $display("%0t: unexpected word code %0d value %0h last %0b", $time,
                         m_tdata[5:0], m_tdata[37:6], m_tlast);
            end else begin
                want = expected_records.pop_front();
                if (m_tdata[5:0] !== want.code || m_tdata[37:6] !== want.value
                        || m_tlast !== want.last) begin
                    errors++;
                    $display("%0t: expected code %0d value %0h last %0b, got %0d %0h %0b",
                             $time, want.code, want.value, want.last,
                             m_tdata[5:0], m_tdata[37:6], m_tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        int n;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        cf_flags = 0; cf_slots = 8; cf_ohw = 7; cf_ltw = 0;
        cf_wb = 16; cf_hb = 16; cf_maxw = 17'h10000; cf_maxh = 17'h10000;
        p_step = P_IDLE; p_cnt = 0; p_acc = 0; p_kind = 0; p_flags = 0;
        p_refs = 0; p_loop = 0; p_bslot = 0; uv_zeros = 0; uv_phase = 0; p_ready = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].st, dir_rows[i].kind, dir_rows[i].b);
            if (dir_rows[i].chk && (word_records.size() == 0
                    || word_records[0].code !== dir_rows[i].code
                    || word_records[0].value !== dir_rows[i].value)) begin
                errors++;
                $display("%0t: directed row %0d expected code %0d value %0h", $time, i,
                         dir_rows[i].code, dir_rows[i].value);
            end
        end
        finish_header();
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            configure_phase(ph);
            send_idle_pct  = (ph % 4 == 1) ? 67 : ((ph % 4 == 3) ? 7 : 0);
            recv_stall_pct = (ph % 4 == 2) ? 67 : ((ph % 4 == 3) ? 7 : 0);
            if (ph == 2) hold_req = 1;
            n = words_sent;
            while (words_sent - n < PHASE_WORDS) begin
                if (p_step == P_IDLE || $urandom_range(39) == 0) begin
                    send_word(1'b1, 3'($urandom_range(7)), 1'($urandom_range(1)));
                    // long zero prefix on a variable length id
                    if ($urandom_range(9) == 0)
                        repeat ($urandom_range(32, 35))
                            send_word(1'b0, 3'($urandom_range(7)), 1'b0);
                end else begin
                    send_random_bit();
                end
            end
            finish_header();
            wait_drained();
        end

        $display("%0d words in, %0d headers begun, %0d records checked", words_sent,
                 headers_begun, records_seen);
        $display("covered six register settings and four idling patterns");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
